### hw/rtl/ffea_pkg.sv
`timescale 1ns / 1ps
// Package for the first-fit extent allocator: sizes, request and status codes,
// sequencer states. Used by first_fit_extent_allocator.
package ffea_pkg;

    localparam int MAX_EXTENTS = 16;
    localparam int IDX_W       = $clog2(MAX_EXTENTS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int HSUM_W      = 17 + CNT_W;

    localparam logic [15:0] CAPACITY_RESET = 16'd1024;

    typedef enum logic [1:0] {
        KIND_CREATE = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_DEFRAG = 2'd2,
        KIND_NOP    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_ROOM  = 3'd1,
        ST_NO_FILE  = 3'd2,
        ST_DELETED  = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLE,
        S_DONE
    } t_state;

endpackage

### hw/rtl/first_fit_extent_allocator.sv
`timescale 1ns / 1ps
// First-fit extent allocator top level: extent table, scan sequencer, output register.
// Depends on ffea_pkg.

// One request walks the extent table (at most 16 extents), one table entry visited per
// cycle, first for the first-fit, lookup or compaction pass, then for the hole sum. A
// create that reuses an extent, or a delete that finds its file, ends its first pass
// early; a no-op skips it. o_stall is high while a request is in work; a finished
// result waits in the output register while the next request is taken.
module first_fit_extent_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_size,
    input  logic [15:0] i_file_id,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_assigned_id,
    output logic [15:0] o_start_block,
    output logic [15:0] o_free_blocks,
    output logic [15:0] o_hole_total
);

    // extent table
    logic [15:0] r_start [ffea_pkg::MAX_EXTENTS];
    logic [15:0] r_end   [ffea_pkg::MAX_EXTENTS];
    logic [15:0] r_owner [ffea_pkg::MAX_EXTENTS];
    logic [ffea_pkg::MAX_EXTENTS-1:0] r_live, n_live;

    ffea_pkg::t_state r_state, n_state;
    ffea_pkg::t_kind  r_kind, n_kind;
    ffea_pkg::t_status r_st, n_st;

    logic [15:0] r_cap, r_free, n_free, r_next_id, n_next_id;
    logic [15:0] r_size, n_size, r_fid, n_fid, r_id, n_id, r_sb, n_sb;
    logic [15:0] r_bound, n_bound;
    logic [ffea_pkg::CNT_W-1:0] r_count, n_count, r_idx, n_idx;
    logic [ffea_pkg::HSUM_W-1:0] r_hsum, n_hsum;
    logic        n_out_load;

    logic        w_en;
    logic [ffea_pkg::IDX_W-1:0] w_addr;
    logic [15:0] w_start, w_end, w_owner;
    logic        w_owner_en;

    logic [ffea_pkg::IDX_W-1:0] ix;
    logic [15:0] cur_start, cur_end, cur_owner, cur_len;
    logic        cur_live, at_end;
    logic [16:0] free_add, app_end;
    logic [15:0] free_take;
    logic [15:0] gap, lenh;

    assign ix        = r_idx[ffea_pkg::IDX_W-1:0];
    assign cur_start = r_start[ix];
    assign cur_end   = r_end[ix];
    assign cur_owner = r_owner[ix];
    assign cur_live  = r_live[ix];
    assign cur_len   = cur_end - cur_start;
    assign at_end    = (r_idx == r_count);
    assign free_add  = {1'b0, r_free} + {1'b0, cur_len};
    assign free_take = (r_size > r_free) ? 16'd0 : r_free - r_size;
    assign app_end   = {1'b0, r_bound} + {1'b0, r_size};
    assign gap       = (r_idx != '0 && cur_start > r_bound) ? cur_start - r_bound : 16'd0;
    assign lenh      = cur_live ? 16'd0 : cur_len;

    assign o_stall = (r_state != ffea_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ffea_pkg::S_IDLE;
            r_cap     <= ffea_pkg::CAPACITY_RESET;
            r_free    <= ffea_pkg::CAPACITY_RESET;
            r_next_id <= '0;
            r_count   <= '0;
            r_live    <= '0;
            o_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_free    <= n_free;
            r_next_id <= n_next_id;
            r_count   <= n_count;
            r_live    <= n_live;
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (n_out_load) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_size  <= n_size;
        r_fid   <= n_fid;
        r_st    <= n_st;
        r_id    <= n_id;
        r_sb    <= n_sb;
        r_bound <= n_bound;
        r_idx   <= n_idx;
        r_hsum  <= n_hsum;
        if (w_en) begin
            r_start[w_addr] <= w_start;
            r_end[w_addr]   <= w_end;
        end
        if (w_owner_en) begin
            r_owner[w_addr] <= w_owner;
        end
        if (n_out_load) begin
            o_status      <= r_st;
            o_assigned_id <= r_id;
            o_start_block <= r_sb;
            o_free_blocks <= r_free;
            o_hole_total  <= (r_hsum > ffea_pkg::HSUM_W'(16'hFFFF)) ? 16'hFFFF
                                                                    : r_hsum[15:0];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_size     = r_size;
        n_fid      = r_fid;
        n_st       = r_st;
        n_id       = r_id;
        n_sb       = r_sb;
        n_bound    = r_bound;
        n_idx      = r_idx;
        n_hsum     = r_hsum;
        n_free     = r_free;
        n_next_id  = r_next_id;
        n_count    = r_count;
        n_live     = r_live;
        n_out_load = 1'b0;
        w_en       = 1'b0;
        w_owner_en = 1'b0;
        w_addr     = ix;
        w_start    = cur_start;
        w_end      = cur_end;
        w_owner    = r_next_id;

        unique case (r_state)
            ffea_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_kind  = ffea_pkg::t_kind'(i_kind);
                    n_size  = i_size;
                    n_fid   = i_file_id;
                    n_st    = ffea_pkg::ST_OK;
                    n_id    = '0;
                    n_sb    = '0;
                    n_bound = '0;
                    n_idx   = '0;
                    if (ffea_pkg::t_kind'(i_kind) == ffea_pkg::KIND_CREATE) begin
                        n_next_id = r_next_id + 16'd1;
                    end
                    n_state = ffea_pkg::S_SCAN;
                end
            end
            ffea_pkg::S_SCAN: begin
                if (at_end || r_kind == ffea_pkg::KIND_NOP) begin
                    n_idx   = '0;
                    n_hsum  = '0;
                    n_state = ffea_pkg::S_HOLE;
                    if (r_kind == ffea_pkg::KIND_CREATE) begin
                        // no freed extent fits: try to append after the last one
                        if (r_size >= r_free) begin
                            n_st = ffea_pkg::ST_NO_ROOM;
                        end else if (r_count == ffea_pkg::CNT_W'(ffea_pkg::MAX_EXTENTS)) begin
                            n_st = ffea_pkg::ST_FULL;
                        end else if (app_end > {1'b0, r_cap}) begin
                            n_st = ffea_pkg::ST_NO_ROOM;
                        end else begin
                            w_en       = 1'b1;
                            w_owner_en = 1'b1;
                            w_addr     = r_count[ffea_pkg::IDX_W-1:0];
                            w_start    = r_bound;
                            w_end      = app_end[15:0];
                            n_live[r_count[ffea_pkg::IDX_W-1:0]] = 1'b1;
                            n_count    = r_count + 1'b1;
                            n_free     = free_take;
                            n_id       = r_next_id;
                            n_sb       = r_bound;
                        end
                    end else if (r_kind == ffea_pkg::KIND_DELETE) begin
                        n_st = ffea_pkg::ST_NO_FILE;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                    case (r_kind)
                        ffea_pkg::KIND_CREATE: begin
                            n_bound = cur_end;
                            if (!cur_live && cur_len >= r_size) begin
                                // reuse this hole, shrunk to the request
                                w_en       = 1'b1;
                                w_owner_en = 1'b1;
                                w_end      = cur_start + r_size;
                                n_live[ix] = 1'b1;
                                n_free     = free_take;
                                n_id       = r_next_id;
                                n_sb       = cur_start;
                                n_idx      = '0;
                                n_hsum     = '0;
                                n_state    = ffea_pkg::S_HOLE;
                            end
                        end
                        ffea_pkg::KIND_DELETE: begin
                            if (cur_owner == r_fid) begin
                                if (!cur_live) begin
                                    n_st = ffea_pkg::ST_DELETED;
                                end else begin
                                    n_live[ix] = 1'b0;
                                    n_free = free_add[16] ? 16'hFFFF : free_add[15:0];
                                end
                                n_idx   = '0;
                                n_hsum  = '0;
                                n_state = ffea_pkg::S_HOLE;
                            end
                        end
                        default: begin
                            // compaction: slide this extent down to the bound
                            if (r_idx != '0 && cur_start != r_bound) begin
                                w_en    = 1'b1;
                                w_start = r_bound;
                                w_end   = r_bound + cur_len;
                                n_bound = r_bound + cur_len;
                            end else begin
                                n_bound = cur_end;
                            end
                        end
                    endcase
                end
            end
            ffea_pkg::S_HOLE: begin
                if (at_end) begin
                    n_state = ffea_pkg::S_DONE;
                end else begin
                    n_hsum  = r_hsum + ffea_pkg::HSUM_W'(lenh) + ffea_pkg::HSUM_W'(gap);
                    n_bound = cur_end;
                    n_idx   = r_idx + 1'b1;
                end
            end
            ffea_pkg::S_DONE: begin
                if (!o_valid || !i_stall) begin
                    n_out_load = 1'b1;
                    n_state    = ffea_pkg::S_IDLE;
                end
            end
            default: n_state = ffea_pkg::S_IDLE;
        endcase
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ffea_pkg::CNT_W'(ffea_pkg::MAX_EXTENTS))
        else $error("extent count beyond table depth");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == ffea_pkg::S_SCAN))
        else $error("accepted beat did not start a scan");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffea_pkg::S_DONE && (!o_valid || !i_stall)) |=> o_valid)
        else $error("finished result not presented");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status <= 3'd4))
        else $error("status code out of range");

endmodule
